FILE: src/leb_pkg.sv
package leb_pkg;

  localparam logic [7:0] KeyEsc     = 8'd27;
  localparam logic [7:0] KeyBack    = 8'd8;
  localparam logic [7:0] KeyEnter   = 8'd13;
  localparam logic [7:0] KeyPrefix  = 8'd224;
  localparam logic [7:0] KeyLeft    = 8'd75;
  localparam logic [7:0] KeyRight   = 8'd77;
  localparam logic [7:0] NewlineChr = 8'd10;

  localparam int DumpLimit = 64;

  typedef enum logic [2:0] {
    OpInsert = 3'd0,
    OpErase  = 3'd1,
    OpLeft   = 3'd2,
    OpRight  = 3'd3,
    OpNop    = 3'd4,
    OpDump   = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    KindStatus = 2'd0,
    KindChar   = 2'd1,
    KindEmpty  = 2'd2
  } kind_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] ch;
  } op_t;

endpackage

FILE: src/leb_if.sv
interface leb_key_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_code;

  modport source (output valid, output key_code, input ready);
  modport sink (input valid, input key_code, output ready);
endinterface

interface leb_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] char_out;
  logic [6:0] cursor_now;
  logic [6:0] length_now;
  logic       dropped;
  logic       last;

  modport source (
    output valid, output kind, output char_out, output cursor_now,
    output length_now, output dropped, output last, input ready
  );
  modport sink (
    input valid, input kind, input char_out, input cursor_now,
    input length_now, input dropped, input last, output ready
  );
endinterface

FILE: src/leb_ram.sv
module leb_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: src/leb_front.sv
module leb_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  leb_key_if.sink        key_i,
  output logic           push_o,
  output leb_pkg::op_t   op_o,
  input  logic           push_ready_i
);

  logic prefix_q, prefix_d;
  logic fire;

  assign key_i.ready = push_ready_i;
  assign fire        = key_i.valid && push_ready_i;
  assign push_o      = key_i.valid;

  always_comb begin
    prefix_d = prefix_q;
    op_o.ch  = key_i.key_code;
    op_o.op  = leb_pkg::OpNop;
    if (prefix_q) begin
      if (key_i.key_code == leb_pkg::KeyLeft) begin
        op_o.op = leb_pkg::OpLeft;
      end else if (key_i.key_code == leb_pkg::KeyRight) begin
        op_o.op = leb_pkg::OpRight;
      end
      if (fire) begin
        prefix_d = 1'b0;
      end
    end else begin
      case (key_i.key_code)
        leb_pkg::KeyEsc:    op_o.op = leb_pkg::OpDump;
        leb_pkg::KeyBack:   op_o.op = leb_pkg::OpErase;
        leb_pkg::KeyPrefix: begin
          op_o.op = leb_pkg::OpNop;
          if (fire) begin
            prefix_d = 1'b1;
          end
        end
        leb_pkg::KeyEnter: begin
          op_o.op = leb_pkg::OpInsert;
          op_o.ch = leb_pkg::NewlineChr;
        end
        default:            op_o.op = leb_pkg::OpInsert;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q <= 1'b0;
    end else begin
      prefix_q <= prefix_d;
    end
  end

endmodule

FILE: src/leb_queue.sv
module leb_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  leb_pkg::op_t op_i,
  output logic         push_ready_o,
  output logic         pop_valid_o,
  output leb_pkg::op_t op_o,
  input  logic         pop_i
);

  leb_pkg::op_t slot_q [2];
  logic         wptr_q, rptr_q;
  logic [1:0]   cnt_q;
  logic         do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign op_o         = slot_q[rptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wptr_q <= ~wptr_q;
      end
      if (do_pop) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

FILE: src/leb_back.sv
module leb_back #(
  parameter int Capacity = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         pop_valid_i,
  input  leb_pkg::op_t op_i,
  output logic         pop_o,
  leb_res_if.source    res_o
);

  localparam int AW = $clog2(Capacity);
  localparam int CW = $clog2(Capacity + 1);

  typedef enum logic [8:0] {
    StIdle     = 9'b000000001,
    StInsRd    = 9'b000000010,
    StInsMv    = 9'b000000100,
    StInsPut   = 9'b000001000,
    StDelRd    = 9'b000010000,
    StDelMv    = 9'b000100000,
    StDumpRd   = 9'b001000000,
    StDumpEmit = 9'b010000000,
    StStatus   = 9'b100000000
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   len_q, len_d, cur_q, cur_d, idx_q, idx_d, lim_q, lim_d;
  logic [7:0]      ch_q, ch_d;
  logic            drop_q, drop_d;
  leb_pkg::kind_e  kind_q, kind_d;

  logic            ov_q, ov_d;
  logic [1:0]      okind_q, okind_d;
  logic [7:0]      ochar_q, ochar_d;
  logic [CW-1:0]   ocur_q, ocur_d, olen_q, olen_d;
  logic            odrop_q, odrop_d, olast_q, olast_d;

  logic            slot_free, load;
  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [7:0]      wdata, rdata;

  leb_ram #(
    .Width (8),
    .Depth (Capacity)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign slot_free = !ov_q || res_o.ready;

  always_comb begin
    state_d = state_q;
    len_d   = len_q;
    cur_d   = cur_q;
    idx_d   = idx_q;
    lim_d   = lim_q;
    ch_d    = ch_q;
    drop_d  = drop_q;
    kind_d  = kind_q;
    pop_o   = 1'b0;
    we      = 1'b0;
    waddr   = AW'(idx_q);
    wdata   = rdata;
    raddr   = AW'(idx_q);
    load    = 1'b0;
    okind_d = okind_q;
    ochar_d = ochar_q;
    ocur_d  = ocur_q;
    olen_d  = olen_q;
    odrop_d = odrop_q;
    olast_d = olast_q;

    case (state_q)
      StIdle: begin
        if (pop_valid_i) begin
          pop_o  = 1'b1;
          ch_d   = op_i.ch;
          drop_d = 1'b0;
          kind_d = leb_pkg::KindStatus;
          state_d = StStatus;
          case (op_i.op)
            leb_pkg::OpInsert: begin
              if (int'(len_q) >= Capacity) begin
                drop_d = 1'b1;
              end else if (len_q == cur_q) begin
                state_d = StInsPut;
              end else begin
                idx_d   = len_q;
                state_d = StInsRd;
              end
            end
            leb_pkg::OpErase: begin
              if (cur_q == '0) begin
                state_d = StStatus;
              end else if (cur_q == len_q) begin
                len_d = len_q - CW'(1);
                cur_d = cur_q - CW'(1);
              end else begin
                idx_d   = cur_q;
                state_d = StDelRd;
              end
            end
            leb_pkg::OpLeft: begin
              if (cur_q != '0) begin
                cur_d = cur_q - CW'(1);
              end
            end
            leb_pkg::OpRight: begin
              if (cur_q < len_q) begin
                cur_d = cur_q + CW'(1);
              end
            end
            leb_pkg::OpDump: begin
              if (len_q == '0) begin
                kind_d = leb_pkg::KindEmpty;
              end else begin
                idx_d   = '0;
                lim_d   = (int'(len_q) > leb_pkg::DumpLimit) ? CW'(leb_pkg::DumpLimit)
                                                              : len_q;
                state_d = StDumpRd;
              end
            end
            default: state_d = StStatus;
          endcase
        end
      end
      StInsRd: begin
        raddr   = AW'(idx_q - CW'(1));
        state_d = StInsMv;
      end
      StInsMv: begin
        we    = 1'b1;
        waddr = AW'(idx_q);
        wdata = rdata;
        raddr = AW'(idx_q - CW'(2));
        idx_d = idx_q - CW'(1);
        if (idx_q - CW'(1) == cur_q) begin
          state_d = StInsPut;
        end
      end
      StInsPut: begin
        we      = 1'b1;
        waddr   = AW'(cur_q);
        wdata   = ch_q;
        len_d   = len_q + CW'(1);
        cur_d   = cur_q + CW'(1);
        state_d = StStatus;
      end
      StDelRd: begin
        raddr   = AW'(idx_q);
        state_d = StDelMv;
      end
      StDelMv: begin
        we    = 1'b1;
        waddr = AW'(idx_q - CW'(1));
        wdata = rdata;
        raddr = AW'(idx_q + CW'(1));
        idx_d = idx_q + CW'(1);
        if (idx_q + CW'(1) == len_q) begin
          len_d   = len_q - CW'(1);
          cur_d   = cur_q - CW'(1);
          state_d = StStatus;
        end
      end
      StDumpRd: begin
        raddr   = AW'(idx_q);
        state_d = StDumpEmit;
      end
      StDumpEmit: begin
        raddr = AW'(idx_q);
        if (slot_free) begin
          load    = 1'b1;
          okind_d = leb_pkg::KindChar;
          ochar_d = rdata;
          ocur_d  = cur_q;
          olen_d  = len_q;
          odrop_d = 1'b0;
          olast_d = (idx_q + CW'(1) == lim_q);
          idx_d   = idx_q + CW'(1);
          state_d = (idx_q + CW'(1) == lim_q) ? StIdle : StDumpRd;
        end
      end
      StStatus: begin
        if (slot_free) begin
          load    = 1'b1;
          okind_d = kind_q;
          ochar_d = '0;
          ocur_d  = cur_q;
          olen_d  = len_q;
          odrop_d = drop_q;
          olast_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase

    ov_d = (ov_q && !res_o.ready) || load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      len_q   <= '0;
      cur_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      cur_q   <= cur_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    lim_q   <= lim_d;
    ch_q    <= ch_d;
    drop_q  <= drop_d;
    kind_q  <= kind_d;
    okind_q <= okind_d;
    ochar_q <= ochar_d;
    ocur_q  <= ocur_d;
    olen_q  <= olen_d;
    odrop_q <= odrop_d;
    olast_q <= olast_d;
  end

  assign res_o.valid      = ov_q;
  assign res_o.kind       = okind_q;
  assign res_o.char_out   = ochar_q;
  assign res_o.cursor_now = 7'(ocur_q);
  assign res_o.length_now = 7'(olen_q);
  assign res_o.dropped    = odrop_q;
  assign res_o.last       = olast_q;

endmodule

FILE: src/line_edit_buffer.sv
// Line editor over a keyboard byte stream. Each key word gives one status word, except
// Escape, which dumps the stored text as one word per character (at most 64, last set on
// the final one) or one empty-dump word. Keys are decoded and queued two deep ahead of the
// edit engine, so up to two keys are taken while an edit runs. The text sits in a
// single-port-write, registered-read RAM of Capacity bytes and the engine moves one
// character per cycle. An insert inside the text moves each character from the end down to
// the cursor one place up, then writes the new one; one at the end writes it at once. A
// backspace inside the text moves each character after the cursor one place down. A
// backspace at the end or at cursor zero, a refused insert, a cursor move, an ignored key and
// an empty dump go straight to their status word. Each status or character word leaves
// through an output register in the cycle after the engine forms it. Store contents are not
// cleared at reset; only characters below the length are ever used.
module line_edit_buffer #(
  parameter int Capacity = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  leb_key_if.sink   key_i,
  leb_res_if.source res_o
);

  logic         push, push_ready, pop_valid, pop;
  leb_pkg::op_t push_op, pop_op;

  leb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .key_i        (key_i),
    .push_o       (push),
    .op_o         (push_op),
    .push_ready_i (push_ready)
  );

  leb_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .op_i         (push_op),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .op_o         (pop_op),
    .pop_i        (pop)
  );

  leb_back #(
    .Capacity (Capacity)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .op_i        (pop_op),
    .pop_o       (pop),
    .res_o       (res_o)
  );

endmodule
